@@ sv/pihp_pkg.sv @@
// shared types and constants of the program image header parser
package pihp_pkg;

    // image layout
    localparam int unsigned HDR_BYTES    = 16;
    localparam int unsigned INSTR_BYTES  = 4;
    localparam logic [4:0]  HDR_LAST_POS = 5'(HDR_BYTES - 1);
    localparam logic [1:0]  INSTR_LAST   = 2'(INSTR_BYTES - 1);

    // configuration register indexes
    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_VERSION = 1'b1;

    // status codes
    localparam logic [2:0] ST_INSTR    = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_MAGIC    = 3'd3;
    localparam logic [2:0] ST_VERSION  = 3'd4;
    localparam logic [2:0] ST_HDR_SIZE = 3'd5;
    localparam logic [2:0] ST_ENTRY    = 3'd6;
    localparam logic [2:0] ST_MISMATCH = 3'd7;

    // one input item
    typedef struct packed {
        logic [7:0] byte_value;
        logic       final_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [7:0]         opcode;
        logic [7:0]         operand_a;
        logic signed [15:0] operand_b;
        logic [2:0]         status;
        logic               end_of_image;
    } t_out_item;

    // up to two result items written to the queue in one cycle
    typedef struct packed {
        logic      valid0;
        t_out_item item0;
        logic      valid1;
        t_out_item item1;
    } t_fifo_wr;

endpackage

@@ sv/pihp_result_fifo.sv @@
// result queue: takes up to two items a cycle, gives one a cycle on pop
module pihp_result_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pihp_pkg::t_fifo_wr  i_wr,
    input  logic                i_pop,
    output pihp_pkg::t_out_item o_item,
    output logic                o_valid,
    output logic                o_almost_full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_HIGH = CNT_W'(DEPTH - 2);

    pihp_pkg::t_out_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_wr_ptr1 = ptr_inc(r_wr_ptr);
    assign w_pop     = i_pop && (r_count != '0);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_wr.valid0 && i_wr.valid1) begin
            n_wr_ptr = ptr_inc(w_wr_ptr1);
        end else if (i_wr.valid0) begin
            n_wr_ptr = w_wr_ptr1;
        end
        if (w_pop) begin
            n_rd_ptr = ptr_inc(r_rd_ptr);
        end
        n_count = r_count + CNT_W'(i_wr.valid0) + CNT_W'(i_wr.valid1) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage, second item goes in behind the first
    always_ff @(posedge i_clk) begin
        if (i_wr.valid0) begin
            r_mem[r_wr_ptr] <= i_wr.item0;
        end
        if (i_wr.valid0 && i_wr.valid1) begin
            r_mem[w_wr_ptr1] <= i_wr.item1;
        end
    end

    assign o_item        = r_mem[r_rd_ptr];
    assign o_valid       = (r_count != '0);
    assign o_almost_full = (r_count > CNT_HIGH);

endmodule

@@ sv/program_image_header_parser_unit.sv @@
// top level of the program image header parser
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (byte, final flag)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (instruction or status)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one byte is taken per cycle while o_in_stall is low; header, record and status
// logic act in the cycle a byte is accepted and its results enter the queue at
// that edge and are offered behind any earlier results; a byte with two results
// (last record byte and final flag) puts both in the queue.
// o_in_stall rises when the queue has fewer than two free entries.
// reset clears all parse state; magic resets to 0 and version to 1.
module program_image_header_parser_unit #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  pihp_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output pihp_pkg::t_out_item o_out_item,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_cfg_ready
);

    logic [31:0]  r_magic;
    logic [15:0]  r_version;
    logic [4:0]   r_hdr_cnt, n_hdr_cnt;
    logic [127:0] r_hdr, n_hdr;
    logic [2:0]   r_fault, n_fault;
    logic [31:0]  r_decl, n_decl;
    logic [31:0]  r_done, n_done;
    logic [23:0]  r_part, n_part;
    logic [1:0]   r_bii, n_bii;
    logic         r_excess, n_excess;

    logic               w_acc;
    logic [7:0]         w_byte;
    logic [127:0]       w_hdr_full;
    logic               w_emit;
    logic [2:0]         w_status;
    pihp_pkg::t_out_item w_instr;
    pihp_pkg::t_out_item w_close;
    pihp_pkg::t_fifo_wr  w_wr;
    logic               w_almost_full;

    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_byte      = i_in_item.byte_value;
    assign o_cfg_ready = 1'b1;
    assign w_hdr_full  = {w_byte, r_hdr[119:0]};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= '0;
            r_version <= 16'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pihp_pkg::CFG_MAGIC:   r_magic   <= i_cfg_data;
                pihp_pkg::CFG_VERSION: r_version <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-byte parse step
    always_comb begin
        n_hdr_cnt = r_hdr_cnt;
        n_hdr     = r_hdr;
        n_fault   = r_fault;
        n_decl    = r_decl;
        n_done    = r_done;
        n_part    = r_part;
        n_bii     = r_bii;
        n_excess  = r_excess;
        w_emit    = 1'b0;
        w_status  = pihp_pkg::ST_OK;

        w_instr.opcode       = r_part[7:0];
        w_instr.operand_a    = r_part[15:8];
        w_instr.operand_b    = {w_byte, r_part[23:16]};
        w_instr.status       = pihp_pkg::ST_INSTR;
        w_instr.end_of_image = 1'b0;

        if (w_acc) begin
            priority if (!r_hdr_cnt[4]) begin
                // header byte
                n_hdr[{r_hdr_cnt[3:0], 3'b000} +: 8] = w_byte;
                n_hdr_cnt = r_hdr_cnt + 5'd1;
                if (r_hdr_cnt == pihp_pkg::HDR_LAST_POS) begin
                    n_decl = w_hdr_full[95:64];
                    priority if (w_hdr_full[31:0] != r_magic) begin
                        n_fault = pihp_pkg::ST_MAGIC;
                    end else if (w_hdr_full[47:32] != r_version) begin
                        n_fault = pihp_pkg::ST_VERSION;
                    end else if (w_hdr_full[63:48] != 16'(pihp_pkg::HDR_BYTES)) begin
                        n_fault = pihp_pkg::ST_HDR_SIZE;
                    end else if (w_hdr_full[127:96] != 32'd0) begin
                        n_fault = pihp_pkg::ST_ENTRY;
                    end else begin
                        n_fault = pihp_pkg::ST_INSTR;
                    end
                end
            end else if (r_bii != pihp_pkg::INSTR_LAST) begin
                // leading bytes of a record
                n_part[{r_bii, 3'b000} +: 8] = w_byte;
                n_bii = r_bii + 2'd1;
            end else begin
                // closing byte of a record
                n_part = '0;
                n_bii  = '0;
                if (r_fault == pihp_pkg::ST_INSTR) begin
                    if (r_done < r_decl) begin
                        w_emit = 1'b1;
                        n_done = r_done + 32'd1;
                    end else begin
                        n_excess = 1'b1;
                    end
                end
            end

            // closing status and restart on the final byte
            if (i_in_item.final_byte) begin
                priority if (!n_hdr_cnt[4]) begin
                    w_status = pihp_pkg::ST_SHORT;
                end else if (n_fault != pihp_pkg::ST_INSTR) begin
                    w_status = n_fault;
                end else if (n_done != n_decl || n_bii != 2'd0 || n_excess) begin
                    w_status = pihp_pkg::ST_MISMATCH;
                end else begin
                    w_status = pihp_pkg::ST_OK;
                end
                n_hdr_cnt = '0;
                n_hdr     = '0;
                n_fault   = pihp_pkg::ST_INSTR;
                n_decl    = '0;
                n_done    = '0;
                n_part    = '0;
                n_bii     = '0;
                n_excess  = 1'b0;
            end
        end
    end

    // closing status item
    always_comb begin
        w_close.opcode       = '0;
        w_close.operand_a    = '0;
        w_close.operand_b    = '0;
        w_close.status       = w_status;
        w_close.end_of_image = 1'b1;
    end

    // queue writes: instruction first, then status
    always_comb begin
        w_wr.valid0 = w_emit || (w_acc && i_in_item.final_byte);
        w_wr.item0  = w_emit ? w_instr : w_close;
        w_wr.valid1 = w_emit && i_in_item.final_byte;
        w_wr.item1  = w_close;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_hdr     <= '0;
            r_fault   <= pihp_pkg::ST_INSTR;
            r_decl    <= '0;
            r_done    <= '0;
            r_part    <= '0;
            r_bii     <= '0;
            r_excess  <= 1'b0;
        end else begin
            r_hdr_cnt <= n_hdr_cnt;
            r_hdr     <= n_hdr;
            r_fault   <= n_fault;
            r_decl    <= n_decl;
            r_done    <= n_done;
            r_part    <= n_part;
            r_bii     <= n_bii;
            r_excess  <= n_excess;
        end
    end

    pihp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_pop         (!i_out_stall),
        .o_item        (o_out_item),
        .o_valid       (o_out_valid),
        .o_almost_full (w_almost_full)
    );

    assign o_in_stall = w_almost_full;

endmodule

@@ sv/pihp_checker.sv @@
// port-level checker of the program image header parser and its bind
module pihp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input pihp_pkg::t_in_item  i_in_item,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input pihp_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a final byte always yields a result in the next cycle
    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.final_byte |=> o_out_valid)
        else $error("no result after final byte");

    // no result appears out of nothing
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !(i_in_valid && !o_in_stall) |=> !o_out_valid)
        else $error("result without accepted byte");

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind program_image_header_parser_unit pihp_checker u_pihp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

@@ verif/tb.sv @@
// testbench of the program image header parser: directed table, random images, byte predictor
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_LIMIT = 5000;
    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned PHASE_BYTES = 70;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DIR_ROW_COUNT = 24;
    localparam logic [2:0] NO_FAULT = 3'd0;

    // one row of the directed table: typed closing status, then the item
    typedef struct packed {
        logic               typed;
        logic [2:0]         closing;
        pihp_pkg::t_in_item item;
    } t_dir_row;

    // short image, one valid image with one record, another short image
    localparam t_dir_row DIR_ROWS [DIR_ROW_COUNT] = '{
        {1'b1, pihp_pkg::ST_SHORT, 8'hFF, 1'b1},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h01, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h10, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h01, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'hFF, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b1, pihp_pkg::ST_OK,    8'h80, 1'b1},
        {1'b0, pihp_pkg::ST_INSTR, 8'h00, 1'b0},
        {1'b0, pihp_pkg::ST_INSTR, 8'h7F, 1'b0},
        {1'b1, pihp_pkg::ST_SHORT, 8'hAA, 1'b1}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    pihp_pkg::t_in_item  i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    pihp_pkg::t_out_item o_out_item;
    logic                i_out_stall;
    logic                i_cfg_valid;
    logic                i_cfg_index;
    logic [31:0]         i_cfg_data;
    logic                o_cfg_ready;

    // parser model state and register copies
    logic [31:0]  cfg_magic = '0;
    logic [15:0]  cfg_version = 16'd1;
    int unsigned  hdr_count = 0;
    logic [127:0] hdr_bits = '0;
    logic [2:0]   hdr_fault = NO_FAULT;
    logic [31:0]  decl_count = '0;
    logic [31:0]  instr_count = '0;
    logic [23:0]  rec_buf = '0;
    int unsigned  rec_pos = 0;
    logic         overrun = 1'b0;

    pihp_pkg::t_out_item parsed_items[$];
    logic [7:0]          img_bytes[$];
    pihp_pkg::t_out_item want_item;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    int unsigned  bytes_sent = 0;
    logic         calm = 1'b0;

    program_image_header_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // advance the parser by one accepted byte and queue what it emits
    task automatic parse_byte(input pihp_pkg::t_in_item it, input logic typed,
                              input logic [2:0] closing);
        pihp_pkg::t_out_item r;
        r = '0;
        if (hdr_count < pihp_pkg::HDR_BYTES) begin
            hdr_bits[hdr_count * 8 +: 8] = it.byte_value;
            hdr_count++;
            if (hdr_count == pihp_pkg::HDR_BYTES) begin
                decl_count = hdr_bits[95:64];
                if (hdr_bits[31:0] != cfg_magic) hdr_fault = pihp_pkg::ST_MAGIC;
                else if (hdr_bits[47:32] != cfg_version) hdr_fault = pihp_pkg::ST_VERSION;
                else if (hdr_bits[63:48] != 16'(pihp_pkg::HDR_BYTES))
                    hdr_fault = pihp_pkg::ST_HDR_SIZE;
                else if (hdr_bits[127:96] != '0) hdr_fault = pihp_pkg::ST_ENTRY;
                else hdr_fault = NO_FAULT;
            end
        end else if (rec_pos < pihp_pkg::INSTR_BYTES - 1) begin
            rec_buf[rec_pos * 8 +: 8] = it.byte_value;
            rec_pos++;
        end else begin
            r.opcode = rec_buf[7:0];
            r.operand_a = rec_buf[15:8];
            r.operand_b = {it.byte_value, rec_buf[23:16]};
            r.status = pihp_pkg::ST_INSTR;
            r.end_of_image = 1'b0;
            rec_buf = '0;
            rec_pos = 0;
            if (hdr_fault == NO_FAULT) begin
                if (instr_count < decl_count) begin
                    parsed_items = {parsed_items, r};
                    instr_count++;
                end else begin
                    overrun = 1'b1;
                end
            end
        end

        // closing status on the last byte, then a fresh image
        if (it.final_byte) begin
            r = '0;
            if (hdr_count < pihp_pkg::HDR_BYTES) r.status = pihp_pkg::ST_SHORT;
            else if (hdr_fault != NO_FAULT) r.status = hdr_fault;
            else if (instr_count != decl_count || rec_pos != 0 || overrun)
                r.status = pihp_pkg::ST_MISMATCH;
            else r.status = pihp_pkg::ST_OK;
            if (typed) r.status = closing;
            r.end_of_image = 1'b1;
            parsed_items = {parsed_items, r};
            hdr_count = 0;
            hdr_bits = '0;
            hdr_fault = NO_FAULT;
            decl_count = '0;
            instr_count = '0;
            rec_buf = '0;
            rec_pos = 0;
            overrun = 1'b0;
        end
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (parsed_items.size() == 0) begin
                report_mismatch($sformatf("unexpected item status %0d", o_out_item.status));
            end else begin
                want_item = parsed_items.pop_front();
                if (o_out_item.opcode !== want_item.opcode)
                    report_mismatch($sformatf("opcode got %0h want %0h",
                                              o_out_item.opcode, want_item.opcode));
                if (o_out_item.operand_a !== want_item.operand_a)
                    report_mismatch($sformatf("operand_a got %0h want %0h",
                                              o_out_item.operand_a, want_item.operand_a));
                if (o_out_item.operand_b !== want_item.operand_b)
                    report_mismatch($sformatf("operand_b got %0h want %0h",
                                              o_out_item.operand_b, want_item.operand_b));
                if (o_out_item.status !== want_item.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_out_item.status, want_item.status));
                if (o_out_item.end_of_image !== want_item.end_of_image)
                    report_mismatch($sformatf("end_of_image got %0b want %0b",
                                              o_out_item.end_of_image, want_item.end_of_image));
            end
        end
    end

    // output stall: runs of no stall, then gaps of random length
    initial begin
        int unsigned run;
        int unsigned gap;
        i_out_stall = 1'b0;
        forever begin
            run = $urandom_range(1, 12);
            repeat (run) @(negedge i_clk) i_out_stall <= 1'b0;
            gap = pick_gap();
            repeat (gap) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    // offer one byte after a random gap and wait for it to be taken
    task automatic send_byte(input pihp_pkg::t_in_item it, input logic typed,
                             input logic [2:0] closing);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        parse_byte(it, typed, closing);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == pihp_pkg::CFG_MAGIC) cfg_magic = data;
        else cfg_version = data[15:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every pending result is out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (parsed_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_le(input logic [31:0] v, input int unsigned nb);
        for (int unsigned i = 0; i < nb; i++) img_bytes = {img_bytes, v[i * 8 +: 8]};
    endtask

    // one random image: mostly well-formed, some short, some with a bad header field
    task automatic build_image();
        int unsigned kind;
        int unsigned bad_field;
        int unsigned recs;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] hsize;
        logic [31:0] count;
        logic [31:0] entry;
        logic [31:0] mask;
        img_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            repeat ($urandom_range(1, pihp_pkg::HDR_BYTES - 1))
                img_bytes = {img_bytes, 8'($urandom)};
            return;
        end
        magic = cfg_magic;
        version = cfg_version;
        hsize = 16'(pihp_pkg::HDR_BYTES);
        entry = '0;
        count = $urandom_range(0, 4);
        if ($urandom_range(0, 19) == 0) count = $urandom;
        recs = count > 6 ? $urandom_range(0, 3) : count;
        if (kind < 24) begin
            do mask = $urandom; while (mask[15:0] == '0);
            bad_field = $urandom_range(0, 3);
            case (bad_field)
                0: magic = magic ^ mask;
                1: version = version ^ mask[15:0];
                2: hsize = hsize ^ mask[15:0];
                default: entry = entry ^ mask;
            endcase
            recs = $urandom_range(0, 3);
        end else begin
            case ($urandom_range(0, 9))
                0: recs = recs + $urandom_range(1, 2);
                1: if (recs > 0) recs = recs - 1;
                default: ;
            endcase
        end
        add_le(magic, 4);
        add_le(32'(version), 2);
        add_le(32'(hsize), 2);
        add_le(count, 4);
        add_le(entry, 4);
        repeat (recs) add_le($urandom, pihp_pkg::INSTR_BYTES);
        // a trailing partial record now and then
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, pihp_pkg::INSTR_BYTES - 1))
                img_bytes = {img_bytes, 8'($urandom)};
    endtask

    // stimulus
    initial begin
        pihp_pkg::t_in_item it;
        int unsigned phase;
        int unsigned phase_start;
        int unsigned drain;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = pihp_pkg::CFG_MAGIC;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under reset register values
        for (int unsigned i = 0; i < DIR_ROW_COUNT; i++)
            send_byte(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].closing);

        // random phases, each under its own register setting
        bytes_sent = 0;
        phase = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            wait_drained();
            case (phase % 4)
                0: begin
                    write_reg(pihp_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
                    write_reg(pihp_pkg::CFG_VERSION, 32'h0000_FFFF);
                end
                1: begin
                    write_reg(pihp_pkg::CFG_MAGIC, 32'h0);
                    write_reg(pihp_pkg::CFG_VERSION, 32'h0);
                end
                default: begin
                    write_reg(pihp_pkg::CFG_MAGIC, $urandom);
                    write_reg(pihp_pkg::CFG_VERSION, 32'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            calm = (phase % 3 == 2);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < RANDOM_BYTES) begin
                build_image();
                for (int unsigned i = 0; i < img_bytes.size(); i++) begin
                    it.byte_value = img_bytes[i];
                    it.final_byte = (i == img_bytes.size() - 1);
                    send_byte(it, 1'b0, pihp_pkg::ST_INSTR);
                end
            end
            phase++;
        end

        // drain and finish
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        drain = 0;
        while (parsed_items.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (parsed_items.size() != 0)
            report_mismatch($sformatf("%0d items never arrived", parsed_items.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/pihp_pkg.sv
sv/pihp_result_fifo.sv
sv/program_image_header_parser_unit.sv
sv/pihp_checker.sv
verif/tb.sv
